// File: sv/mdsf_pkg.sv
// mdsf_pkg: constants, types and codes for the mixdown sample fifo
// no dependencies; imported by the interfaces and every module of the block
package mdsf_pkg;

    localparam int DEPTH       = 1024;
    localparam int CHANNELS    = 8;
    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEVEL_W     = 11;
    localparam int ACTION_W    = 2;
    localparam int COUNT_W     = 4;
    localparam int TOTAL_W     = 64;
    localparam int SUM_W       = SAMPLE_W + $clog2(CHANNELS);
    localparam int DIV_STEP_W  = $clog2(SUM_W);
    localparam int CAP_MIN     = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [LEVEL_W-1:0]         t_level;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [TOTAL_W-1:0]         t_total;

    typedef struct packed {
        logic   start;
        t_sum   num;
        t_count den;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_sample quot;
    } t_div_rsp;

endpackage

// File: sv/mdsf_if.sv
// mdsf_in_if, mdsf_out_if, mdsf_cfg_if: valid/ready channels of the fifo
// depends on mdsf_pkg
interface mdsf_in_if;
    import mdsf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    t_count                channel_count;
    logic [CHANNELS-1:0]   channel_present;
    t_sample               sample_0;
    t_sample               sample_1;
    t_sample               sample_2;
    t_sample               sample_3;
    t_sample               sample_4;
    t_sample               sample_5;
    t_sample               sample_6;
    t_sample               sample_7;

    modport source (output valid, action, channel_count, channel_present, sample_0, sample_1,
                    sample_2, sample_3, sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink   (input valid, action, channel_count, channel_present, sample_0, sample_1,
                    sample_2, sample_3, sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface mdsf_out_if;
    import mdsf_pkg::*;
    logic    valid;
    logic    ready;
    logic    accepted;
    logic    read_valid;
    t_sample read_sample;
    t_level  fill_level;
    t_total  total_written;
    t_total  dropped_count;

    modport source (output valid, accepted, read_valid, read_sample, fill_level,
                    total_written, dropped_count, input ready);
    modport sink   (input valid, accepted, read_valid, read_sample, fill_level,
                    total_written, dropped_count, output ready);
endinterface

interface mdsf_cfg_if;
    import mdsf_pkg::*;
    logic   valid;
    logic   ready;
    t_level capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// File: sv/mdsf_div.sv
// mdsf_div: bit-serial restoring divider for the channel average
// one quotient bit per cycle, truncates toward zero; depends on mdsf_pkg
module mdsf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdsf_pkg::t_div_req i_req,
    output mdsf_pkg::t_div_rsp o_rsp
);
    import mdsf_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]      r_work;
    t_count                r_rem;
    t_count                r_den;
    logic                  r_neg;

    logic [COUNT_W:0]      rem_sh;
    logic                  ge;
    logic [COUNT_W:0]      rem_sub;
    logic [SUM_W-1:0]      quot_s;

    always_comb begin
        rem_sh  = {r_rem, r_work[SUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
        quot_s  = r_neg ? (~r_work + 1'b1) : r_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_req.num[SUM_W-1];
                r_work <= i_req.num[SUM_W-1] ? (~i_req.num + 1'b1) : i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_work <= {r_work[SUM_W-2:0], ge};
                r_rem  <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = quot_s[SAMPLE_W-1:0];

endmodule

// File: sv/mdsf_store.sv
// mdsf_store: sample memory of the fifo, one write and one read port
// read data registered; depends on mdsf_pkg
module mdsf_store (
    input  logic             i_clk,
    input  logic             i_we,
    input  mdsf_pkg::t_addr  i_waddr,
    input  mdsf_pkg::t_sample i_wdata,
    input  logic             i_re,
    input  mdsf_pkg::t_addr  i_raddr,
    output mdsf_pkg::t_sample o_rdata
);
    import mdsf_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mixdown_sample_fifo_unit.sv
// mixdown_sample_fifo_unit: top level of the mixdown sample fifo
// depends on mdsf_pkg, the channel interfaces, mdsf_div and mdsf_store
//
// i_in carries one action per transfer: push a frame of up to eight channels,
// pop the oldest sample, or clear pointers and counters. o_out returns exactly
// one result per action with the fill level and both counters after it.
// i_cfg writes the capacity register (clamped to 2..1024 when used); write it
// only while no action is in flight.
// Actions run one at a time. A push of at most one present channel, a dropped
// push, a push with no channels offered, a clear, a pop from an empty fifo or
// an unknown action goes straight to the result; a pop that returns a sample
// first waits for the memory read, and a push averaging several channels waits
// for the divider, which produces one quotient bit per cycle over 19 bits.
// The result shows on o_out in the cycle after the last step.
// The output register holds a result while the receiver stalls, and i_in
// already takes the next action; that action then waits for the output
// register before it finishes.
// Reset empties the fifo, zeroes both counters and sets capacity to 1024; the
// sample memory is not cleared and is only read where it was written.
module mixdown_sample_fifo_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdsf_in_if.sink     i_in,
    mdsf_out_if.source  o_out,
    mdsf_cfg_if.sink    i_cfg
);
    import mdsf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_POPRD = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    function automatic t_addr f_advance(t_addr p, t_level cap);
        t_level nxt;
        nxt = LEVEL_W'(p) + 1'b1;
        return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
    endfunction

    logic [1:0] r_state, n_state;
    t_level     r_capacity;
    t_addr      r_wptr, n_wptr;
    t_addr      r_rptr, n_rptr;
    t_level     r_occ, n_occ;
    t_total     r_written, n_written;
    t_total     r_dropped, n_dropped;
    logic       r_acc, n_acc;
    logic       r_rvalid, n_rvalid;
    t_sample    r_rsample, n_rsample;

    logic       r_out_valid;
    logic       r_o_acc;
    logic       r_o_rvalid;
    t_sample    r_o_rsample;
    t_level     r_o_level;
    t_total     r_o_written;
    t_total     r_o_dropped;

    t_level     eff_cap;
    logic       in_xfer;
    logic       out_load;
    t_count     count_eff;
    t_sample    samples [CHANNELS];
    t_sum       sum;
    t_count     n_ch;

    logic       store_we;
    t_sample    store_wdata;
    logic       store_re;
    t_sample    store_rdata;
    t_div_req   div_req;
    t_div_rsp   div_rsp;

    assign samples[0] = i_in.sample_0;
    assign samples[1] = i_in.sample_1;
    assign samples[2] = i_in.sample_2;
    assign samples[3] = i_in.sample_3;
    assign samples[4] = i_in.sample_4;
    assign samples[5] = i_in.sample_5;
    assign samples[6] = i_in.sample_6;
    assign samples[7] = i_in.sample_7;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_capacity < LEVEL_W'(CAP_MIN)) begin
            eff_cap = LEVEL_W'(CAP_MIN);
        end else if (r_capacity > LEVEL_W'(DEPTH)) begin
            eff_cap = LEVEL_W'(DEPTH);
        end else begin
            eff_cap = r_capacity;
        end
    end

    // mix of the present channels among the offered ones
    always_comb begin
        count_eff = (i_in.channel_count > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS)
                                                              : i_in.channel_count;
        sum  = '0;
        n_ch = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if ((COUNT_W'(ch) < count_eff) && i_in.channel_present[ch]) begin
                sum  = sum + SUM_W'(samples[ch]);
                n_ch = n_ch + 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_occ       = r_occ;
        n_written   = r_written;
        n_dropped   = r_dropped;
        n_acc       = r_acc;
        n_rvalid    = r_rvalid;
        n_rsample   = r_rsample;
        store_we    = 1'b0;
        store_wdata = sum[SAMPLE_W-1:0];
        store_re    = 1'b0;
        div_req     = '{start: 1'b0, num: sum, den: n_ch};

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_acc     = 1'b0;
                    n_rvalid  = 1'b0;
                    n_rsample = '0;
                    n_state   = S_DONE;
                    case (i_in.action)
                        ACT_PUSH: begin
                            if (i_in.channel_count != '0) begin
                                if (r_occ >= eff_cap) begin
                                    n_dropped = r_dropped + 1'b1;
                                end else if (n_ch > COUNT_W'(1)) begin
                                    div_req.start = 1'b1;
                                    n_state       = S_DIV;
                                end else begin
                                    store_we  = 1'b1;
                                    n_wptr    = f_advance(r_wptr, eff_cap);
                                    n_occ     = r_occ + 1'b1;
                                    n_written = r_written + 1'b1;
                                    n_acc     = 1'b1;
                                end
                            end
                        end
                        ACT_POP: begin
                            if (r_occ != '0) begin
                                store_re = 1'b1;
                                n_rptr   = f_advance(r_rptr, eff_cap);
                                n_occ    = r_occ - 1'b1;
                                n_state  = S_POPRD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_wptr    = '0;
                            n_rptr    = '0;
                            n_occ     = '0;
                            n_written = '0;
                            n_dropped = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                store_wdata = div_rsp.quot;
                if (div_rsp.done) begin
                    store_we  = 1'b1;
                    n_wptr    = f_advance(r_wptr, eff_cap);
                    n_occ     = r_occ + 1'b1;
                    n_written = r_written + 1'b1;
                    n_acc     = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_POPRD: begin
                n_rsample = store_rdata;
                n_rvalid  = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= LEVEL_W'(DEPTH);
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_occ       <= '0;
            r_written   <= '0;
            r_dropped   <= '0;
            r_acc       <= 1'b0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wptr    <= n_wptr;
            r_rptr    <= n_rptr;
            r_occ     <= n_occ;
            r_written <= n_written;
            r_dropped <= n_dropped;
            r_acc     <= n_acc;
            r_rvalid  <= n_rvalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_rsample <= n_rsample;
        if (out_load) begin
            r_o_acc     <= r_acc;
            r_o_rvalid  <= r_rvalid;
            r_o_rsample <= r_rsample;
            r_o_level   <= r_occ;
            r_o_written <= r_written;
            r_o_dropped <= r_dropped;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_o_acc;
    assign o_out.read_valid    = r_o_rvalid;
    assign o_out.read_sample   = r_o_rsample;
    assign o_out.fill_level    = r_o_level;
    assign o_out.total_written = r_o_written;
    assign o_out.dropped_count = r_o_dropped;

    mdsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mdsf_store u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_wptr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (r_rptr),
        .o_rdata (store_rdata)
    );

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= LEVEL_W'(DEPTH))
        else $error("occupancy above memory depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_we |-> (r_occ < eff_cap))
        else $error("sample written into a full fifo");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("second transfer taken while an action is in flight");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_re |=> (r_state == S_POPRD))
        else $error("memory read without pop capture");

    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_dropped == $past(r_dropped)
                                 || r_dropped == $past(r_dropped) + 1'b1
                                 || r_dropped == '0))
        else $error("drop counter jumped");

endmodule
